// ===== sv/ssp_pkg.sv =====
// shared types and constants for the stepper slot positioner
package ssp_pkg;

    localparam logic [7:0] STEPS_PER_REV = 8'd200;
    localparam logic [3:0] NUM_SLOTS     = 4'd6;
    localparam int         NUM_SLOT_REGS = 6;

    localparam logic [7:0]  SLOT_RESET [NUM_SLOT_REGS] = '{
        8'd3, 8'd170, 8'd137, 8'd103, 8'd69, 8'd36
    };
    localparam logic [15:0] STEP_INTERVAL_RESET = 16'd20000;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_GOTO   = 2'd1,
        OP_HOME   = 2'd2,
        OP_SETPOS = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_BAD_ARG = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_SLOT0         = 3'd0,
        CFG_SLOT1         = 3'd1,
        CFG_SLOT2         = 3'd2,
        CFG_SLOT3         = 3'd3,
        CFG_SLOT4         = 3'd4,
        CFG_SLOT5         = 3'd5,
        CFG_STEP_INTERVAL = 3'd6
    } t_cfg_index;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_MOVE  = 4'b0010,
        MODE_SWEEP = 4'b0100,
        MODE_PAUSE = 4'b1000
    } t_run_mode;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] slot_number;
        logic [7:0] new_position;
    } t_in_item;

    typedef struct packed {
        logic [3:0] coil_drive;
        logic [7:0] step_position;
        logic [1:0] drive_phase;
        logic       busy_res;
        logic [1:0] status;
        logic       arrived;
    } t_out_item;

endpackage

// ===== sv/stepper_slot_positioner.sv =====
// stepper slot positioner top level: command decode, step sequencing and result register
//
// usage
//   input channel i_in_valid/o_in_ready carries one tick or command per transaction
//   (tick, goto slot, home, set position). every accepted transaction yields exactly
//   one result transaction on o_out_valid/i_out_ready with the coil drive, step
//   position, phase, busy flag, status and arrival pulse after that transaction.
//   the result is registered and is valid in the cycle after input accept; throughput
//   is one transaction per cycle while the receiver accepts results, set by the
//   single state update between the input handshake and the result register.
//   when the receiver stalls, the result register holds its transaction and the
//   input side takes a new transaction only in the cycle the held result leaves.
//   the configuration port writes slot positions (index 0 to 5) and the step
//   interval (index 6) through i_cfg_we; writes to other indexes are ignored.
//   a synchronous active-low reset idles the motor, clears position, phase and
//   coils, restores the default slot table and interval, and empties the result
//   register.
module stepper_slot_positioner
    import ssp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    logic [7:0]  r_slot_pos [NUM_SLOT_REGS];
    logic [15:0] r_interval;

    logic [7:0]  r_step,    n_step;
    logic [1:0]  r_phase,   n_phase;
    logic [7:0]  r_target,  n_target;
    logic [15:0] r_counter, n_counter;
    logic [7:0]  r_sweep,   n_sweep;
    t_run_mode   r_mode,    n_mode;
    logic [3:0]  r_coil,    n_coil;

    logic        r_out_valid;
    t_out_item   r_out,     n_out;

    logic        in_fire;
    logic        busy;
    logic [16:0] tick_next;
    logic [16:0] tick_limit;
    logic [7:0]  down_step;
    logic [7:0]  up_step;
    logic [7:0]  slot_raw;
    logic [7:0]  slot_tgt;
    logic [7:0]  home_tgt;
    t_status     status;
    logic        arrived;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign busy       = (r_mode != MODE_IDLE);
    assign tick_next  = {1'b0, r_counter} + 17'd1;
    assign tick_limit = (r_interval == 16'd0) ? 17'd1 : {1'b0, r_interval};

    assign down_step = (r_step == 8'd0 || r_step >= STEPS_PER_REV) ?
                       (STEPS_PER_REV - 8'd1) : (r_step - 8'd1);
    assign up_step   = (r_step >= STEPS_PER_REV - 8'd1) ? 8'd0 : (r_step + 8'd1);

    // slot table lookup with out-of-range positions clamped to the last step
    assign slot_raw = ({1'b0, i_in_data.slot_number} < 4'(NUM_SLOT_REGS)) ?
                      r_slot_pos[i_in_data.slot_number] : 8'd0;
    assign slot_tgt = (slot_raw >= STEPS_PER_REV) ? (STEPS_PER_REV - 8'd1) : slot_raw;
    assign home_tgt = (r_slot_pos[0] >= STEPS_PER_REV) ?
                      (STEPS_PER_REV - 8'd1) : r_slot_pos[0];

    always_comb begin
        n_step    = r_step;
        n_phase   = r_phase;
        n_target  = r_target;
        n_counter = r_counter;
        n_sweep   = r_sweep;
        n_mode    = r_mode;
        n_coil    = r_coil;
        status    = ST_OK;
        arrived   = 1'b0;

        unique case (t_op'(i_in_data.operation))
            OP_TICK: begin
                if (busy) begin
                    if (tick_next >= tick_limit) begin
                        n_counter = 16'd0;
                        unique case (r_mode)
                            MODE_MOVE: begin
                                if (r_step > r_target) begin
                                    n_step  = down_step;
                                    n_phase = r_phase - 2'd1;
                                    n_coil  = 4'b0001 << n_phase;
                                end else if (r_step < r_target) begin
                                    n_step  = up_step;
                                    n_phase = r_phase + 2'd1;
                                    n_coil  = 4'b0001 << n_phase;
                                end
                                if (n_step == r_target) begin
                                    n_mode  = MODE_IDLE;
                                    arrived = 1'b1;
                                end
                            end
                            MODE_SWEEP: begin
                                n_step  = down_step;
                                n_phase = r_phase - 2'd1;
                                n_coil  = 4'b0001 << n_phase;
                                if (r_sweep != 8'd0) begin
                                    n_sweep = r_sweep - 8'd1;
                                end
                                if (n_sweep == 8'd0) begin
                                    n_mode = MODE_PAUSE;
                                end
                            end
                            MODE_PAUSE: begin
                                n_step   = 8'd0;
                                n_target = home_tgt;
                                if (home_tgt == 8'd0) begin
                                    n_mode  = MODE_IDLE;
                                    arrived = 1'b1;
                                end else begin
                                    n_mode = MODE_MOVE;
                                end
                            end
                            default: begin
                                n_mode = r_mode;
                            end
                        endcase
                    end else begin
                        n_counter = tick_next[15:0];
                    end
                end
            end
            OP_GOTO: begin
                if (busy) begin
                    status = ST_BUSY;
                end else if ({1'b0, i_in_data.slot_number} >= NUM_SLOTS) begin
                    status = ST_BAD_ARG;
                end else begin
                    n_target  = slot_tgt;
                    n_counter = 16'd0;
                    if (r_step == slot_tgt) begin
                        arrived = 1'b1;
                    end else begin
                        n_mode = MODE_MOVE;
                    end
                end
            end
            OP_HOME: begin
                if (busy) begin
                    status = ST_BUSY;
                end else begin
                    n_sweep   = STEPS_PER_REV;
                    n_counter = 16'd0;
                    n_mode    = MODE_SWEEP;
                end
            end
            OP_SETPOS: begin
                if (busy) begin
                    status = ST_BUSY;
                end else if (i_in_data.new_position >= STEPS_PER_REV) begin
                    status = ST_BAD_ARG;
                end else begin
                    n_step = i_in_data.new_position;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase

        n_out.coil_drive    = n_coil;
        n_out.step_position = n_step;
        n_out.drive_phase   = n_phase;
        n_out.busy_res      = (n_mode != MODE_IDLE);
        n_out.status        = status;
        n_out.arrived       = arrived;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 8'd0;
            r_phase     <= 2'd0;
            r_target    <= 8'd0;
            r_counter   <= 16'd0;
            r_sweep     <= 8'd0;
            r_mode      <= MODE_IDLE;
            r_coil      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_step    <= n_step;
                r_phase   <= n_phase;
                r_target  <= n_target;
                r_counter <= n_counter;
                r_sweep   <= n_sweep;
                r_mode    <= n_mode;
                r_coil    <= n_coil;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOT_REGS; i++) begin
                r_slot_pos[i] <= SLOT_RESET[i];
            end
            r_interval <= STEP_INTERVAL_RESET;
        end else if (i_cfg_we) begin
            if (t_cfg_index'(i_cfg_index) == CFG_STEP_INTERVAL) begin
                r_interval <= i_cfg_wdata;
            end else if ({1'b0, i_cfg_index} < 4'(NUM_SLOT_REGS)) begin
                r_slot_pos[i_cfg_index] <= i_cfg_wdata[7:0];
            end
        end
    end

`ifndef SYNTH
    a_coil_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_coil))
        else $error("coil drive has more than one coil on");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < STEPS_PER_REV)
        else $error("step position out of range");

    a_counter_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (r_counter == 16'd0))
        else $error("interval counter running while idle");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted transaction produced no result");

    a_arrived_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.arrived && r_out.busy_res))
        else $error("arrival reported while still busy");
`endif

endmodule

// ===== verif/tb_stepper_slot_positioner.sv =====
// self-checking testbench for the stepper slot positioner with a predicting scoreboard
module tb_stepper_slot_positioner;
    timeunit 1ns;
    timeprecision 1ps;
    import ssp_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;

    class motor_scoreboard;
        logic [7:0]  slot_reg [NUM_SLOT_REGS];
        logic [15:0] interval_reg;
        logic [7:0]  position;
        logic [1:0]  phase;
        logic [7:0]  target;
        logic [15:0] tick_count;
        logic [7:0]  sweep_left;
        t_run_mode   mode;
        logic [3:0]  coils;
        t_out_item   expected_drive_q [$];
        int          mismatches;
        int          effective_items;

        function new();
            for (int s = 0; s < NUM_SLOT_REGS; s++) begin
                slot_reg[s] = SLOT_RESET[s];
            end
            interval_reg    = STEP_INTERVAL_RESET;
            position        = '0;
            phase           = '0;
            target          = '0;
            tick_count      = '0;
            sweep_left      = '0;
            mode            = MODE_IDLE;
            coils           = '0;
            mismatches      = 0;
            effective_items = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [15:0] data);
            if (index <= CFG_SLOT5) begin
                slot_reg[index] = data[7:0];
            end else if (index == CFG_STEP_INTERVAL) begin
                interval_reg = data;
            end
        endfunction

        function logic [7:0] slot_goal(int s);
            if (slot_reg[s] >= STEPS_PER_REV) begin
                return STEPS_PER_REV - 8'd1;
            end
            return slot_reg[s];
        endfunction

        function bit motor_busy();
            return mode != MODE_IDLE;
        endfunction

        function int pending();
            return expected_drive_q.size();
        endfunction

        function void step_down();
            if (position == 8'd0 || position >= STEPS_PER_REV) begin
                position = STEPS_PER_REV - 8'd1;
            end else begin
                position = position - 8'd1;
            end
            phase = phase - 2'd1;
            coils = 4'b0001 << phase;
        endfunction

        function void step_up();
            if (position >= STEPS_PER_REV - 8'd1) begin
                position = '0;
            end else begin
                position = position + 8'd1;
            end
            phase = phase + 2'd1;
            coils = 4'b0001 << phase;
        endfunction

        function bit begin_move(logic [7:0] goal);
            target     = goal;
            tick_count = '0;
            if (position == goal) begin
                mode = MODE_IDLE;
                return 1'b1;
            end
            mode = MODE_MOVE;
            return 1'b0;
        endfunction

        function void note_command(t_in_item item);
            t_out_item   want;
            t_status     st;
            logic        arr;
            logic [16:0] next_count;
            logic [16:0] limit;
            st  = ST_OK;
            arr = 1'b0;
            if (item.operation != OP_TICK || mode != MODE_IDLE) begin
                effective_items++;
            end
            if (item.operation == OP_TICK) begin
                if (mode != MODE_IDLE) begin
                    limit      = (interval_reg == 16'd0) ? 17'd1 : {1'b0, interval_reg};
                    next_count = {1'b0, tick_count} + 17'd1;
                    if (next_count >= limit) begin
                        tick_count = '0;
                        case (mode)
                            MODE_MOVE: begin
                                if (position > target) begin
                                    step_down();
                                end else if (position < target) begin
                                    step_up();
                                end
                                if (position == target) begin
                                    mode = MODE_IDLE;
                                    arr  = 1'b1;
                                end
                            end
                            MODE_SWEEP: begin
                                step_down();
                                if (sweep_left > 8'd0) begin
                                    sweep_left = sweep_left - 8'd1;
                                end
                                if (sweep_left == 8'd0) begin
                                    mode = MODE_PAUSE;
                                end
                            end
                            default: begin
                                position = '0;
                                arr      = begin_move(slot_goal(0));
                            end
                        endcase
                    end else begin
                        tick_count = next_count[15:0];
                    end
                end
            end else if (mode != MODE_IDLE) begin
                st = ST_BUSY;
            end else if (item.operation == OP_GOTO) begin
                if (item.slot_number >= NUM_SLOTS) begin
                    st = ST_BAD_ARG;
                end else begin
                    arr = begin_move(slot_goal(item.slot_number));
                end
            end else if (item.operation == OP_HOME) begin
                sweep_left = STEPS_PER_REV;
                tick_count = '0;
                mode       = MODE_SWEEP;
            end else if (item.new_position >= STEPS_PER_REV) begin
                st = ST_BAD_ARG;
            end else begin
                position = item.new_position;
            end
            want.coil_drive    = coils;
            want.step_position = position;
            want.drive_phase   = phase;
            want.busy_res      = (mode != MODE_IDLE);
            want.status        = st;
            want.arrived       = arr;
            expected_drive_q.push_back(want);
        endfunction

        function string describe(t_out_item r);
            return $sformatf("coils %b pos %0d phase %0d busy %b status %0d arrived %b",
                             r.coil_drive, r.step_position, r.drive_phase, r.busy_res,
                             r.status, r.arrived);
        endfunction

        function void check_drive_state(t_out_item got);
            t_out_item want;
            if (expected_drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with no transaction pending: %s", $realtime,
                             describe(got));
                end
                return;
            end
            want = expected_drive_q.pop_front();
            if (got.coil_drive !== want.coil_drive || got.step_position !== want.step_position ||
                got.drive_phase !== want.drive_phase || got.busy_res !== want.busy_res ||
                got.status !== want.status || got.arrived !== want.arrived) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch expected %s", $realtime, describe(want));
                    $display("%0t:          actual   %s", $realtime, describe(got));
                end
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_data;

    int send_idle_pct = 17;
    int recv_idle_pct = 54;
    int hold_off_left = 0;

    motor_scoreboard sb = new();

    stepper_slot_positioner i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random stalls plus long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_drive_state(o_out_data);
        end
    end

    function automatic t_in_item make_item(t_op op, logic [2:0] slot, logic [7:0] npos);
        t_in_item item;
        item.operation    = op;
        item.slot_number  = slot;
        item.new_position = npos;
        return item;
    endfunction

    function automatic t_in_item random_item(t_op op);
        return make_item(op, 3'($urandom_range(7)), 8'($urandom_range(255)));
    endfunction

    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.note_command(item);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_cfg(input logic [2:0] index, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(index, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_random_slots();
        int         s;
        logic [7:0] v;
        for (s = 0; s < NUM_SLOT_REGS; s++) begin
            if ($urandom_range(99) < 15) begin
                v = 8'($urandom_range(255, 200));
            end else begin
                v = 8'($urandom_range(199));
            end
            write_cfg(3'(s), {8'($urandom_range(255)), v});
        end
        write_cfg(CFG_UNUSED, 16'($urandom));
    endtask

    // ticks until the move or homing is over, with the odd rejected command
    task automatic tick_until_idle(input int cap);
        int left;
        left = cap;
        while (sb.motor_busy() && left > 0) begin
            if ($urandom_range(19) == 0) begin
                send_item(random_item(t_op'(2'($urandom_range(3, 1)))));
            end else begin
                send_item(random_item(OP_TICK));
            end
            left--;
        end
    endtask

    task automatic run_motion_batch(input int n_items);
        int         start;
        int         pick;
        int         s;
        int         near;
        logic [7:0] goal;
        start = sb.effective_items;
        while (sb.effective_items - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_item(random_item(t_op'(2'($urandom_range(3)))));
            end else if (pick < 18) begin
                send_item(random_item(OP_HOME));
            end else begin
                if ($urandom_range(9) == 0) begin
                    s = $urandom_range(7);
                end else begin
                    s = $urandom_range(NUM_SLOT_REGS - 1);
                end
                if (pick < 65 && s < NUM_SLOT_REGS) begin
                    goal = sb.slot_goal(s);
                    near = int'(goal) + $urandom_range(10) - 5;
                    if (near < 0) begin
                        near = 0;
                    end else if (near > 199) begin
                        near = 199;
                    end
                    send_item(make_item(OP_SETPOS, 3'($urandom_range(7)), 8'(near)));
                end else if (pick < 80) begin
                    send_item(random_item(OP_SETPOS));
                end
                send_item(make_item(OP_GOTO, 3'(s), 8'($urandom_range(255))));
            end
            tick_until_idle(2000);
            if ($urandom_range(3) == 0) begin
                send_item(random_item(OP_TICK));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes, rejects and goto at target with the reset setup
        send_item(make_item(OP_TICK, 3'd7, 8'd255));
        send_item(make_item(OP_SETPOS, 3'd0, 8'd255));
        send_item(make_item(OP_SETPOS, 3'd7, 8'd200));
        send_item(make_item(OP_SETPOS, 3'd0, 8'd199));
        send_item(make_item(OP_GOTO, 3'd7, 8'd0));
        send_item(make_item(OP_GOTO, 3'd6, 8'd0));
        send_item(make_item(OP_SETPOS, 3'd0, 8'd3));
        send_item(make_item(OP_GOTO, 3'd0, 8'd0));
        send_item(make_item(OP_GOTO, 3'd1, 8'd0));
        send_item(make_item(OP_HOME, 3'd0, 8'd0));
        send_item(make_item(OP_TICK, 3'd0, 8'd0));
        wait_drained();

        // zero interval, clamped slots, unused index
        write_cfg(CFG_SLOT2, 16'hFFFF);
        write_cfg(CFG_SLOT3, 16'd200);
        write_cfg(CFG_UNUSED, 16'hFFFF);
        write_cfg(CFG_STEP_INTERVAL, 16'd0);
        tick_until_idle(400);
        send_item(make_item(OP_SETPOS, 3'd0, 8'd199));
        send_item(make_item(OP_GOTO, 3'd2, 8'd0));
        send_item(make_item(OP_GOTO, 3'd3, 8'd0));
        send_item(make_item(OP_SETPOS, 3'd0, 8'd197));
        send_item(make_item(OP_GOTO, 3'd2, 8'd0));
        send_item(make_item(OP_SETPOS, 3'd0, 8'd0));
        send_item(make_item(OP_GOTO, 3'd7, 8'd0));
        send_item(make_item(OP_TICK, 3'd0, 8'd0));
        send_item(make_item(OP_TICK, 3'd0, 8'd0));
        wait_drained();

        // slot extremes, interval 1
        write_cfg(CFG_SLOT0, 16'd0);
        write_cfg(CFG_SLOT1, 16'd199);
        write_cfg(CFG_SLOT2, 16'hAB00 | 16'd255);
        write_cfg(CFG_SLOT3, 16'd200);
        write_cfg(CFG_SLOT4, 16'd1);
        write_cfg(CFG_SLOT5, 16'd100);
        write_cfg(CFG_STEP_INTERVAL, 16'd1);
        run_motion_batch(140);
        wait_drained();
        load_random_slots();
        write_cfg(CFG_STEP_INTERVAL, 16'd0);
        run_motion_batch(140);
        wait_drained();

        // longest interval: a move that barely starts, then a short interval
        write_cfg(CFG_STEP_INTERVAL, 16'hFFFF);
        send_item(make_item(OP_SETPOS, 3'($urandom_range(7)), 8'($urandom_range(199))));
        send_item(make_item(OP_GOTO, 3'($urandom_range(NUM_SLOT_REGS - 1)), 8'd0));
        repeat (40) begin
            if ($urandom_range(7) == 0) begin
                send_item(random_item(t_op'(2'($urandom_range(3, 1)))));
            end else begin
                send_item(random_item(OP_TICK));
            end
        end
        wait_drained();
        write_cfg(CFG_STEP_INTERVAL, 16'd2);
        run_motion_batch(140);
        wait_drained();

        send_idle_pct = 54;
        recv_idle_pct = 17;
        load_random_slots();
        write_cfg(CFG_STEP_INTERVAL, 16'd1);
        run_motion_batch(140);
        wait_drained();
        load_random_slots();
        write_cfg(CFG_STEP_INTERVAL, 16'd3);
        run_motion_batch(140);
        wait_drained();
        load_random_slots();
        write_cfg(CFG_STEP_INTERVAL, 16'($urandom_range(4, 1)));
        run_motion_batch(140);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_left = 80;
        load_random_slots();
        write_cfg(CFG_STEP_INTERVAL, 16'd1);
        run_motion_batch(140);
        wait_drained();

        // homing that ends on slot zero, then one that moves on
        write_cfg(CFG_SLOT0, 16'd0);
        write_cfg(CFG_STEP_INTERVAL, 16'd0);
        send_item(random_item(OP_HOME));
        tick_until_idle(2000);
        wait_drained();
        write_cfg(CFG_SLOT0, 16'd5);
        send_item(random_item(OP_HOME));
        tick_until_idle(2000);
        wait_drained();
        load_random_slots();
        write_cfg(CFG_STEP_INTERVAL, 16'd2);
        run_motion_batch(140);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
